// ----- rtl/dkx_pkg.sv -----
// dkx_pkg: shared constants and types for the DNA k-mer extractor.
// No dependencies; imported by dkx_core and dna_kmer_extractor.
`default_nettype none

package dkx_pkg;

  localparam int DEF_MAX_KMER      = 32;
  localparam int DEF_POSITION_BITS = 48;
  localparam int MIN_KMER          = 12;

  localparam int KMER_W = 64;
  localparam int POS_W  = 48;
  localparam int KLEN_W = 6;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_EOL  = 1'b1;

  localparam logic REG_KMER_LENGTH = 1'b0;
  localparam logic REG_SKIP_HEADER = 1'b1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(MIN_KMER);

  typedef struct packed {
    logic              valid;
    logic [KMER_W-1:0] kmer_bases;
    logic [POS_W-1:0]  start_position;
  } dkx_res_t;

endpackage

`default_nettype wire

// ----- rtl/dkx_core.sv -----
// dkx_core: window, fill and position state, updated on each taken item.
// Depends on dkx_pkg; res is combinational, valid when a k-mer completes.
`default_nettype none

module dkx_core import dkx_pkg::*; #(
  parameter int MAX_KMER      = DEF_MAX_KMER,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic              mode,
  input  wire logic [7:0]        char_code,
  input  wire logic [KLEN_W-1:0] kmer_length,
  input  wire logic              skip_header_line,
  output dkx_res_t               res
);

  localparam int FW = $clog2(MAX_KMER + 1);
  localparam int WW = 2 * MAX_KMER;

  logic [WW-1:0]            window_r, window_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic [POSITION_BITS-1:0] next_start_r, next_start_nxt;
  logic [POSITION_BITS-1:0] chars_seen_r, chars_seen_nxt;
  logic                     first_line_r, first_line_nxt;

  logic [FW-1:0]            k_eff;
  logic [FW-1:0]            fill_inc;
  logic                     is_base;
  logic [1:0]               code;
  logic [WW-1:0]            window_sh;
  logic [WW-1:0]            kmer_mask;
  logic [POSITION_BITS-1:0] chars_inc;
  logic [63:0]              pos_ext;

  always_comb begin
    if (kmer_length < KLEN_W'(MIN_KMER)) begin
      k_eff = FW'(MIN_KMER);
    end else if (kmer_length > KLEN_W'(MAX_KMER)) begin
      k_eff = FW'(MAX_KMER);
    end else begin
      k_eff = kmer_length[FW-1:0];
    end
  end

  always_comb begin
    is_base = 1'b1;
    case (char_code)
      CHAR_A:  code = BASE_A;
      CHAR_C:  code = BASE_C;
      CHAR_G:  code = BASE_G;
      CHAR_T:  code = BASE_T;
      default: begin
        code    = BASE_A;
        is_base = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_KMER; i++) begin
      kmer_mask[2*i +: 2] = (FW'(i) < k_eff) ? 2'b11 : 2'b00;
    end
  end

  assign window_sh = {window_r[WW-3:0], code};
  assign fill_inc  = fill_r + FW'(1);
  assign chars_inc = chars_seen_r + POSITION_BITS'(1);
  assign pos_ext   = 64'(next_start_r);

  always_comb begin
    window_nxt     = window_r;
    fill_nxt       = fill_r;
    next_start_nxt = next_start_r;
    chars_seen_nxt = chars_seen_r;
    first_line_nxt = first_line_r;
    res.valid          = 1'b0;
    res.kmer_bases     = KMER_W'(window_sh & kmer_mask);
    res.start_position = pos_ext[POS_W-1:0];
    if (take) begin
      if (mode == MODE_EOL) begin
        first_line_nxt = 1'b0;
      end else if (!(skip_header_line && first_line_r)) begin
        chars_seen_nxt = chars_inc;
        if (!is_base) begin
          window_nxt     = '0;
          fill_nxt       = '0;
          next_start_nxt = chars_inc + POSITION_BITS'(1);
        end else begin
          window_nxt = window_sh;
          if (fill_inc >= k_eff) begin
            res.valid      = 1'b1;
            fill_nxt       = k_eff - FW'(1);
            next_start_nxt = next_start_r + POSITION_BITS'(1);
          end else begin
            fill_nxt = fill_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      fill_r       <= '0;
      next_start_r <= POSITION_BITS'(1);
      chars_seen_r <= '0;
      first_line_r <= 1'b1;
    end else begin
      window_r     <= window_nxt;
      fill_r       <= fill_nxt;
      next_start_r <= next_start_nxt;
      chars_seen_r <= chars_seen_nxt;
      first_line_r <= first_line_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dna_kmer_extractor.sv -----
// dna_kmer_extractor: a result goes to the result register, or to the skid
// entry under output stall. Throughput 1 item per cycle when in_stall is low.
// A result register plus one skid entry decouple the result stall; the input
// stalls only while the skid entry is occupied.
// Reset (synchronous, rst_n low) empties the window and result registers,
// restores k = 12, header skip off, start position 1.
`default_nettype none

module dna_kmer_extractor import dkx_pkg::*; #(
  parameter int MAX_KMER      = DEF_MAX_KMER,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_char_code,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KMER_W-1:0]      out_kmer_bases,
  output logic [POS_W-1:0]       out_start_position,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [KLEN_W-1:0] cfg_wdata
);

  logic [KLEN_W-1:0] kmer_length_r;
  logic              skip_header_r;
  logic              take;
  logic              out_free;
  dkx_res_t          res;
  dkx_res_t          out_r, out_nxt;
  dkx_res_t          skid_r, skid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= KLEN_RESET;
      skip_header_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KMER_LENGTH: kmer_length_r <= cfg_wdata;
        REG_SKIP_HEADER: skip_header_r <= cfg_wdata[0];
        default:         kmer_length_r <= kmer_length_r;
      endcase
    end
  end

  assign in_stall = skid_r.valid;
  assign take     = in_valid && !in_stall;
  assign out_free = !out_r.valid || !out_stall;

  dkx_core #(
    .MAX_KMER      (MAX_KMER),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .mode             (in_mode),
    .char_code        (in_char_code),
    .kmer_length      (kmer_length_r),
    .skip_header_line (skip_header_r),
    .res              (res)
  );

  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (out_free) begin
      if (skid_r.valid) begin
        out_nxt        = skid_r;
        skid_nxt.valid = 1'b0;
      end else begin
        out_nxt = res;
      end
    end else if (res.valid) begin
      skid_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      out_r.valid  <= out_nxt.valid;
      skid_r.valid <= skid_nxt.valid;
    end
    out_r.kmer_bases      <= out_nxt.kmer_bases;
    out_r.start_position  <= out_nxt.start_position;
    skid_r.kmer_bases     <= skid_nxt.kmer_bases;
    skid_r.start_position <= skid_nxt.start_position;
  end

  assign out_valid          = out_r.valid;
  assign out_kmer_bases     = out_r.kmer_bases;
  assign out_start_position = out_r.start_position;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> out_r.valid)
    else $error("skid entry held with empty result register");

  a_res_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> take)
    else $error("result produced without an accepted item");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && out_stall && res.valid) |=> (out_r.valid && skid_r.valid))
    else $error("result lost under output stall");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for dna_kmer_extractor: streams DNA text items with
// random idling on both sides and checks every k-mer against its own predictor.
// Depends on dkx_pkg and the dna_kmer_extractor RTL.

module testbench;
  import dkx_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic       mode;
    logic [7:0] code;
  } txt_item_t;

  typedef struct packed {
    logic [KMER_W-1:0] kmer;
    logic [POS_W-1:0]  pos;
  } kmer_hit_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_CHAR;
  logic [7:0]        in_char_code = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KMER_W-1:0] out_kmer_bases;
  logic [POS_W-1:0]  out_start_position;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_KMER_LENGTH;
  logic [KLEN_W-1:0] cfg_wdata = KLEN_RESET;

  txt_item_t pending_items[$];
  kmer_hit_t kmer_hits[$];
  kmer_hit_t got_hit;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b0;

  // predictor state and configuration
  logic [KMER_W-1:0] win;
  int unsigned       fill;
  logic [POS_W-1:0]  next_pos;
  logic [POS_W-1:0]  chars_seen;
  bit                first_line;
  logic [KLEN_W-1:0] klen;
  bit                skip_hdr;

  dna_kmer_extractor i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kmer_bases     (out_kmer_bases),
    .out_start_position (out_start_position),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void extract_step(input logic mode, input logic [7:0] ch);
    int unsigned k;
    logic [KMER_W-1:0] keep;
    logic [1:0] code;
    bit is_base;
    kmer_hit_t hit;
    if (mode == MODE_EOL) begin
      first_line = 1'b0;
      return;
    end
    if (skip_hdr && first_line) return;
    chars_seen = chars_seen + 1'b1;
    is_base = 1'b1;
    code = BASE_A;
    case (ch)
      CHAR_A: code = BASE_A;
      CHAR_C: code = BASE_C;
      CHAR_G: code = BASE_G;
      CHAR_T: code = BASE_T;
      default: is_base = 1'b0;
    endcase
    if (!is_base) begin
      win = '0;
      fill = 0;
      next_pos = chars_seen + 1'b1;
      return;
    end
    win = {win[KMER_W-3:0], code};
    fill++;
    k = 32'(klen);
    if (k < MIN_KMER) k = MIN_KMER;
    if (k > DEF_MAX_KMER) k = DEF_MAX_KMER;
    if (fill < k) return;
    keep = (2 * k >= KMER_W) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    hit.kmer = win & keep;
    hit.pos = next_pos;
    kmer_hits.push_back(hit);
    fill = k - 1;
    next_pos = next_pos + 1'b1;
  endfunction

  // driver: offer pending items, hold a stalled item
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_mode <= pending_items[0].mode;
        in_char_code <= pending_items[0].code;
        void'(pending_items.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_count = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_count++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && rx_count >= 120) begin
        hold_done = 1'b1;
        hold_left = 399;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check results, predict accepted items, track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      win = '0;
      fill = 0;
      next_pos = POS_W'(1);
      chars_seen = '0;
      first_line = 1'b1;
      klen = KLEN_RESET;
      skip_hdr = 1'b0;
      kmer_hits.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (kmer_hits.size() == 0) begin
          $error("result with none expected: kmer_bases %h start_position %0d",
                 out_kmer_bases, out_start_position);
          fails++;
        end else begin
          got_hit = kmer_hits.pop_front();
          if (out_kmer_bases !== got_hit.kmer) begin
            $error("kmer_bases expected %h actual %h", got_hit.kmer, out_kmer_bases);
            fails++;
          end
          if (out_start_position !== got_hit.pos) begin
            $error("start_position expected %0d actual %0d", got_hit.pos,
                   out_start_position);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        extract_step(in_mode, in_char_code);
        n_accepted++;
      end
      if (cfg_we) begin
        if (cfg_index == REG_KMER_LENGTH) klen = cfg_wdata;
        else skip_hdr = cfg_wdata[0];
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic queue_item(input logic mode, input logic [7:0] code);
    txt_item_t it;
    it.mode = mode;
    it.code = code;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_item(MODE_CHAR, s[i]);
  endtask

  task automatic queue_random_item();
    int unsigned r;
    logic [7:0] junk [6];
    junk = '{8'h61, 8'h63, 8'h67, 8'h74, 8'h0D, 8'h4E};
    r = $urandom_range(0, 99);
    if (r < 92) begin
      case ($urandom_range(0, 3))
        0: queue_item(MODE_CHAR, CHAR_A);
        1: queue_item(MODE_CHAR, CHAR_C);
        2: queue_item(MODE_CHAR, CHAR_G);
        default: queue_item(MODE_CHAR, CHAR_T);
      endcase
    end else if (r < 96) begin
      queue_item(MODE_EOL, 8'($urandom));
    end else if (r < 98) begin
      queue_item(MODE_CHAR, junk[$urandom_range(0, 5)]);
    end else begin
      queue_item(MODE_CHAR, 8'($urandom));
    end
  endtask

  task automatic write_reg(input logic idx, input logic [KLEN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || kmer_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [KLEN_W-1:0] lengths[$];
    lengths = '{6'd12, 6'd32, 6'd0, 6'd63, 6'd11, 6'd13, 6'd33, 6'd31, 6'd20, 6'd16};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_SKIP_HEADER, 6'd1);
    write_reg(REG_KMER_LENGTH, 6'd12);

    // header line, then bases spanning a newline, then window breaks
    queue_text("XA");
    queue_item(MODE_CHAR, 8'hFF);
    queue_item(MODE_CHAR, 8'h00);
    queue_item(MODE_EOL, 8'hA5);
    queue_text("ACGTACGT");
    queue_item(MODE_EOL, 8'h0A);
    queue_text("ACGTT");
    queue_item(MODE_CHAR, 8'h61);
    queue_item(MODE_CHAR, 8'h0D);
    wait_drained();

    for (int p = 0; p < lengths.size() + 2; p++) begin
      write_reg(REG_KMER_LENGTH,
                p < lengths.size() ? lengths[p] : KLEN_W'($urandom_range(0, 63)));
      write_reg(REG_SKIP_HEADER, KLEN_W'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();
      wait_drained();
    end

    idle_on = 1'b0;
    write_reg(REG_KMER_LENGTH, KLEN_W'($urandom_range(12, 32)));
    for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();
    wait_drained();
    repeat (8) @(posedge clk);

    if (fails == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dkx_pkg.sv
rtl/dkx_core.sv
rtl/dna_kmer_extractor.sv
tb/sv/testbench.sv
